/* hw/rtl/assert_macros.svh */
// Assertion shorthands, clocked on clk and disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ant, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ant, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

/* hw/rtl/hltd_pkg.sv */
`timescale 1ns / 1ps
package hltd_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned KIND_W = 2;
	localparam int unsigned PHASE_W = 2;
	localparam int unsigned CFG_IDX_W = 1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HEAD = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TAIL = 1'd1;

	// Result kinds
	localparam logic [KIND_W-1:0] KIND_DATA = 2'd0;
	localparam logic [KIND_W-1:0] KIND_TAIL_OK = 2'd1;
	localparam logic [KIND_W-1:0] KIND_TAIL_BAD = 2'd2;

	// Deframer phases
	localparam logic [PHASE_W-1:0] PH_HUNT = 2'd0;
	localparam logic [PHASE_W-1:0] PH_LEN = 2'd1;
	localparam logic [PHASE_W-1:0] PH_DATA = 2'd2;
	localparam logic [PHASE_W-1:0] PH_TAIL = 2'd3;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [BYTE_W-1:0] data_byte;
		logic [BYTE_W-1:0] byte_index;
		logic [BYTE_W-1:0] frame_length;
	} res_t;

	// Handshake between the step logic and the result register
	typedef struct packed {
		logic has_res;
		logic load;
	} step_ctrl_t;

endpackage

/* hw/rtl/hltd_in_reg.sv */
`timescale 1ns / 1ps
module hltd_in_reg import hltd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  logic [BYTE_W-1:0] rx_byte,
	input  logic              advance,
	output logic              valid_s1,
	output logic [BYTE_W-1:0] byte_s1
);

	logic take;

	// Hold the byte while the step stage cannot move
	assign item_stall = valid_s1 & ~advance;
	assign take = item_valid & ~item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= rx_byte;
		end
	end

endmodule

/* hw/rtl/hltd_fsm.sv */
`timescale 1ns / 1ps
module hltd_fsm import hltd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  logic [BYTE_W-1:0] byte_s1,
	input  logic [BYTE_W-1:0] head_q,
	input  logic [BYTE_W-1:0] tail_q,
	output logic              has_res,
	output res_t              res
);

	logic [PHASE_W-1:0] phase_q, phase_d;
	logic [BYTE_W-1:0]  len_q, len_d;
	logic [BYTE_W-1:0]  cnt_q, cnt_d;
	logic [BYTE_W-1:0]  cnt_inc;

	assign cnt_inc = cnt_q + 8'd1;

	// One step of the frame parser per byte
	always_comb begin
		phase_d = phase_q;
		len_d = len_q;
		cnt_d = cnt_q;
		has_res = 1'b0;
		res = '0;
		case (phase_q)
			PH_HUNT: begin
				if (byte_s1 == head_q) phase_d = PH_LEN;
			end
			PH_LEN: begin
				len_d = byte_s1;
				cnt_d = '0;
				phase_d = (byte_s1 == '0) ? PH_TAIL : PH_DATA;
			end
			PH_DATA: begin
				has_res = 1'b1;
				res.kind = KIND_DATA;
				res.data_byte = byte_s1;
				res.byte_index = cnt_q;
				res.frame_length = len_q;
				cnt_d = cnt_inc;
				if (cnt_inc == len_q) phase_d = PH_TAIL;
			end
			PH_TAIL: begin
				has_res = 1'b1;
				res.kind = (byte_s1 == tail_q) ? KIND_TAIL_OK : KIND_TAIL_BAD;
				res.frame_length = len_q;
				phase_d = PH_HUNT;
				len_d = '0;
				cnt_d = '0;
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			len_q <= '0;
			cnt_q <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			len_q <= len_d;
			cnt_q <= cnt_d;
		end
	end

endmodule

/* hw/rtl/hltd_out_reg.sv */
`timescale 1ns / 1ps
module hltd_out_reg import hltd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  step_ctrl_t ctrl,
	input  res_t       res,
	output logic       can_take,
	output logic       result_valid,
	input  logic       result_stall,
	output res_t       res_q
);

	// Free when empty or being drained this cycle
	assign can_take = ~result_valid | ~result_stall;

	// A step with no result leaves a waiting beat in place
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (ctrl.load && ctrl.has_res) begin
			result_valid <= 1'b1;
		end else if (~result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load && ctrl.has_res) begin
			res_q <= res;
		end
	end

endmodule

/* hw/rtl/head_length_tail_deframer.sv */
`timescale 1ns / 1ps
// A byte is held in the input register; its result then goes into the result register.
// Throughput: one byte per cycle while the step can move; one parser state update per byte sets the rate.
// Bytes that give no result (hunting, length byte) pass the step stage even while a result is stalled.
// Reset (arst_n low, asynchronous): parser back to hunting, length and count zero,
// head and tail values zero, input and result stages empty.
`include "assert_macros.svh"
module head_length_tail_deframer import hltd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_data,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  logic [BYTE_W-1:0]    rx_byte,
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic [KIND_W-1:0]    kind,
	output logic [BYTE_W-1:0]    data_byte,
	output logic [BYTE_W-1:0]    byte_index,
	output logic [BYTE_W-1:0]    frame_length
);

	logic [BYTE_W-1:0] head_q, tail_q;
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              advance;
	logic              has_res;
	logic              can_take;
	res_t              res, res_q;
	step_ctrl_t        ctrl;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_HEAD: head_q <= cfg_data;
				REG_TAIL: tail_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Step moves when it has no result or the result register is free
	assign advance = valid_s1 & (~has_res | can_take);
	assign ctrl = '{has_res: has_res, load: advance};

	hltd_in_reg u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.rx_byte    (rx_byte),
		.advance    (advance),
		.valid_s1   (valid_s1),
		.byte_s1    (byte_s1)
	);

	hltd_fsm u_fsm (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.byte_s1 (byte_s1),
		.head_q  (head_q),
		.tail_q  (tail_q),
		.has_res (has_res),
		.res     (res)
	);

	hltd_out_reg u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.res          (res),
		.can_take     (can_take),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.res_q        (res_q)
	);

	assign kind = res_q.kind;
	assign data_byte = res_q.data_byte;
	assign byte_index = res_q.byte_index;
	assign frame_length = res_q.frame_length;

	// Checks
	`ASSERT_SAME(a_idx_in_frame, result_valid && kind == KIND_DATA, byte_index < frame_length)
	`ASSERT_SAME(a_end_zeroed, result_valid && kind != KIND_DATA, data_byte == '0 && byte_index == '0)
	`ASSERT_SAME(a_stall_cause, item_stall, result_valid && result_stall)
	`ASSERT_NEXT(a_hunt_no_res, valid_s1 && !has_res && advance && !(result_valid && result_stall), !result_valid)

endmodule
